// ===== sv/tbrp_pkg.sv =====
`default_nettype none

package tbrp_pkg;

	localparam int NUM_BUFFERS  = 5;
	localparam int BUFFER_BYTES = 64;

	localparam int IDX_W     = $clog2(NUM_BUFFERS);
	localparam int FILL_W    = $clog2(BUFFER_BYTES + 1);
	localparam int MEM_DEPTH = NUM_BUFFERS * BUFFER_BYTES;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	// fill plus message length, wide enough for the room check
	localparam int SUM_W     = $clog2(BUFFER_BYTES + 256) + 1;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		OP_HDR = 2'd0,
		OP_PAY = 2'd1,
		OP_TX  = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BUF_NEW     = 2'd0,
		BUF_READY   = 2'd1,
		BUF_FULL    = 2'd2,
		BUF_SENDING = 2'd3
	} buf_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_HDR_OPEN,
		CMD_HDR_DROP,
		CMD_HDR_PLACE,
		CMD_LAUNCH_STEP,
		CMD_PAYLOAD,
		CMD_TX_READ,
		CMD_TX_STOP,
		CMD_TX_BYTE
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic w_open;       // write buffer is new or ready
		logic sending;
		logic launch_more;  // read buffer is full and empty: release and go on
		logic tx_ok;        // a stored byte is left to send
		logic tx_end;       // the byte being sent is the last of its buffer
	} dp_status_t;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(NUM_BUFFERS - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== sv/tbrp_dp.sv =====
`default_nettype none

module tbrp_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tbrp_pkg::dp_cmd_t              cmd,
	output tbrp_pkg::dp_status_t                status,
	input  wire logic [1:0]                     item_op,
	input  wire logic [tbrp_pkg::IN_DATA_W-1:0] item_data,
	output logic [tbrp_pkg::OUT_DATA_W-1:0]     res_data,
	output logic                                res_tx_valid,
	output logic                                res_tx_last
);

	// item under work
	tbrp_pkg::op_t op_q;
	logic [7:0]    len_q;
	logic [7:0]    data_q;

	// ring state
	tbrp_pkg::buf_state_t             stat_q [tbrp_pkg::NUM_BUFFERS];
	logic [tbrp_pkg::FILL_W-1:0]      fill_q [tbrp_pkg::NUM_BUFFERS];
	logic [tbrp_pkg::IDX_W-1:0]       wr_idx_q;
	logic [tbrp_pkg::IDX_W-1:0]       rd_idx_q;
	logic                             sending_q;
	logic [tbrp_pkg::FILL_W-1:0]      send_off_q;
	logic [tbrp_pkg::IDX_W-1:0]       pend_buf_q;
	logic [tbrp_pkg::FILL_W-1:0]      pend_off_q;
	logic [7:0]                       pend_left_q;
	logic [7:0]                       drop_q;

	// result
	logic acc_q;
	logic txv_q;
	logic txl_q;

	// byte store
	logic [7:0] mem [tbrp_pkg::MEM_DEPTH];
	logic [7:0] rdata_q;

	logic [tbrp_pkg::IDX_W-1:0]  w;
	logic [tbrp_pkg::IDX_W-1:0]  wn;
	logic [tbrp_pkg::IDX_W-1:0]  r;
	logic                        room_w;
	logic                        room_wn;
	logic                        launch_go;
	logic                        launch_more;
	logic [tbrp_pkg::ADDR_W-1:0] wr_addr;
	logic [tbrp_pkg::ADDR_W-1:0] rd_addr;
	logic                        pay_ok;

	always_comb begin
		w  = wr_idx_q;
		wn = tbrp_pkg::next_idx(wr_idx_q);
		r  = rd_idx_q;
		room_w  = (tbrp_pkg::SUM_W'(fill_q[w]) + tbrp_pkg::SUM_W'(len_q))
			< tbrp_pkg::SUM_W'(tbrp_pkg::BUFFER_BYTES);
		room_wn = (tbrp_pkg::SUM_W'(fill_q[wn]) + tbrp_pkg::SUM_W'(len_q))
			< tbrp_pkg::SUM_W'(tbrp_pkg::BUFFER_BYTES);
		launch_go   = (stat_q[r] == tbrp_pkg::BUF_FULL) && (fill_q[r] != '0);
		launch_more = (stat_q[r] == tbrp_pkg::BUF_FULL) && (fill_q[r] == '0);
		pay_ok = (pend_left_q != '0)
			&& (pend_off_q < tbrp_pkg::FILL_W'(tbrp_pkg::BUFFER_BYTES));
		wr_addr = tbrp_pkg::ADDR_W'(pend_buf_q) * tbrp_pkg::ADDR_W'(tbrp_pkg::BUFFER_BYTES)
			+ tbrp_pkg::ADDR_W'(pend_off_q);
		rd_addr = tbrp_pkg::ADDR_W'(r) * tbrp_pkg::ADDR_W'(tbrp_pkg::BUFFER_BYTES)
			+ tbrp_pkg::ADDR_W'(send_off_q);

		status.op          = op_q;
		status.w_open      = stat_q[w] inside {tbrp_pkg::BUF_NEW, tbrp_pkg::BUF_READY};
		status.sending     = sending_q;
		status.launch_more = launch_more;
		status.tx_ok       = (send_off_q < fill_q[r])
			&& (send_off_q < tbrp_pkg::FILL_W'(tbrp_pkg::BUFFER_BYTES));
		status.tx_end      = (send_off_q + 1'b1) >= fill_q[r];
	end

	// item and result registers
	always_ff @(posedge clk) begin
		case (cmd.cmd)
			tbrp_pkg::CMD_LOAD: begin
				op_q   <= tbrp_pkg::op_t'(item_op);
				len_q  <= item_data[7:0];
				data_q <= item_data[15:8];
				acc_q  <= 1'b0;
				txv_q  <= 1'b0;
				txl_q  <= 1'b0;
			end
			tbrp_pkg::CMD_HDR_PLACE: begin
				acc_q <= room_w || ((stat_q[wn] == tbrp_pkg::BUF_NEW) && room_wn);
			end
			tbrp_pkg::CMD_TX_BYTE: begin
				txv_q <= 1'b1;
				txl_q <= status.tx_end;
			end
			default: begin
			end
		endcase
	end

	// byte store: one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.cmd == tbrp_pkg::CMD_PAYLOAD && pay_ok) begin
			mem[wr_addr] <= data_q;
		end
		if (cmd.cmd == tbrp_pkg::CMD_TX_READ) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tbrp_pkg::NUM_BUFFERS; i++) begin
				stat_q[i] <= tbrp_pkg::BUF_NEW;
				fill_q[i] <= '0;
			end
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			sending_q   <= 1'b0;
			send_off_q  <= '0;
			pend_buf_q  <= '0;
			pend_off_q  <= '0;
			pend_left_q <= '0;
			drop_q      <= '0;
		end else begin
			case (cmd.cmd)
				tbrp_pkg::CMD_HDR_OPEN: begin
					pend_left_q <= '0;
					stat_q[w]   <= tbrp_pkg::BUF_READY;
				end
				tbrp_pkg::CMD_HDR_DROP: begin
					pend_left_q <= '0;
					drop_q      <= drop_q + 1'b1;
				end
				tbrp_pkg::CMD_HDR_PLACE: begin
					if (room_w) begin
						pend_buf_q  <= w;
						pend_off_q  <= fill_q[w];
						pend_left_q <= len_q;
					end else begin
						stat_q[w] <= tbrp_pkg::BUF_FULL;
						wr_idx_q  <= wn;
						if (stat_q[wn] == tbrp_pkg::BUF_NEW && room_wn) begin
							pend_buf_q  <= wn;
							pend_off_q  <= fill_q[wn];
							pend_left_q <= len_q;
							stat_q[wn]  <= tbrp_pkg::BUF_READY;
						end else begin
							drop_q <= drop_q + 1'b1;
						end
					end
				end
				tbrp_pkg::CMD_LAUNCH_STEP: begin
					if (launch_go) begin
						stat_q[r]  <= tbrp_pkg::BUF_SENDING;
						sending_q  <= 1'b1;
						send_off_q <= '0;
					end else if (launch_more) begin
						stat_q[r] <= tbrp_pkg::BUF_NEW;
						fill_q[r] <= '0;
						rd_idx_q  <= tbrp_pkg::next_idx(r);
					end
				end
				tbrp_pkg::CMD_PAYLOAD: begin
					if (pay_ok) begin
						pend_off_q          <= pend_off_q + 1'b1;
						fill_q[pend_buf_q]  <= pend_off_q + 1'b1;
						pend_left_q         <= pend_left_q - 1'b1;
					end else begin
						pend_left_q <= '0;
					end
				end
				tbrp_pkg::CMD_TX_STOP: begin
					sending_q  <= 1'b0;
					send_off_q <= '0;
				end
				tbrp_pkg::CMD_TX_BYTE: begin
					if (status.tx_end) begin
						if (stat_q[r] != tbrp_pkg::BUF_SENDING) begin
							drop_q <= drop_q + 1'b1;
						end
						stat_q[r]  <= tbrp_pkg::BUF_NEW;
						fill_q[r]  <= '0;
						sending_q  <= 1'b0;
						send_off_q <= '0;
						rd_idx_q   <= tbrp_pkg::next_idx(r);
					end else begin
						send_off_q <= send_off_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// fields from bit 0: accepted, tx_byte, loss_count, zero fill
	assign res_data = {7'b0, drop_q, (txv_q ? rdata_q : 8'h00), acc_q};
	assign res_tx_valid = txv_q;
	assign res_tx_last  = txl_q;

`ifndef SYNTH
	a_send_owner: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q |-> stat_q[rd_idx_q] == tbrp_pkg::BUF_SENDING)
		else $error("transmitter busy without a sending buffer");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_idx_q < tbrp_pkg::IDX_W'(tbrp_pkg::NUM_BUFFERS))
		&& (rd_idx_q < tbrp_pkg::IDX_W'(tbrp_pkg::NUM_BUFFERS)))
		else $error("ring pointer out of range");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(drop_q != $past(drop_q)) |-> (drop_q == $past(drop_q) + 8'd1))
		else $error("loss counter jumped");
`endif

endmodule

`default_nettype wire

// ===== sv/tbrp_ctrl.sv =====
`default_nettype none

module tbrp_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire tbrp_pkg::dp_status_t status,
	output tbrp_pkg::dp_cmd_t         cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_LAUNCH = 6'b000100,
		S_HDR    = 6'b001000,
		S_TXRD   = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	logic                       ret_hdr_q;  // after launch, finish a header
	logic [tbrp_pkg::IDX_W-1:0] lcnt_q;     // releases done in this launch

	always_comb begin
		state_d   = state_q;
		cmd.cmd   = tbrp_pkg::CMD_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cmd = tbrp_pkg::CMD_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
				case (status.op)
					tbrp_pkg::OP_HDR: begin
						if (status.w_open) begin
							cmd.cmd = tbrp_pkg::CMD_HDR_OPEN;
							state_d = status.sending ? S_HDR : S_LAUNCH;
						end else begin
							cmd.cmd = tbrp_pkg::CMD_HDR_DROP;
						end
					end
					tbrp_pkg::OP_PAY: begin
						cmd.cmd = tbrp_pkg::CMD_PAYLOAD;
					end
					tbrp_pkg::OP_TX: begin
						if (status.sending && status.tx_ok) begin
							cmd.cmd = tbrp_pkg::CMD_TX_READ;
							state_d = S_TXRD;
						end else if (status.sending) begin
							cmd.cmd = tbrp_pkg::CMD_TX_STOP;
						end
					end
					default: begin
					end
				endcase
			end
			S_LAUNCH: begin
				cmd.cmd = tbrp_pkg::CMD_LAUNCH_STEP;
				if (!status.launch_more
					|| lcnt_q == tbrp_pkg::IDX_W'(tbrp_pkg::NUM_BUFFERS - 1)) begin
					state_d = ret_hdr_q ? S_HDR : S_OUT;
				end
			end
			S_HDR: begin
				cmd.cmd = tbrp_pkg::CMD_HDR_PLACE;
				state_d = S_OUT;
			end
			S_TXRD: begin
				cmd.cmd = tbrp_pkg::CMD_TX_BYTE;
				state_d = status.tx_end ? S_LAUNCH : S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_hdr_q <= 1'b0;
			lcnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_d == S_LAUNCH && state_q != S_LAUNCH) begin
				lcnt_q    <= '0;
				ret_hdr_q <= (state_q == S_EXEC);
			end else if (state_q == S_LAUNCH) begin
				lcnt_q <= lcnt_q + 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_launch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LAUNCH) |-> (lcnt_q < tbrp_pkg::IDX_W'(tbrp_pkg::NUM_BUFFERS)))
		else $error("launch ran past the ring");

	a_hdr_after_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HDR) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_LAUNCH))
		else $error("header placement entered from a wrong step");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");
`endif

endmodule

`default_nettype wire

// ===== sv/transmit_buffer_ring_packer.sv =====
`default_nettype none

// Transmit buffer ring packer. Messages are packed into a ring of
// tbrp_pkg::NUM_BUFFERS buffers of tbrp_pkg::BUFFER_BYTES bytes. Each
// request on the slave side carries an opcode in s_tuser: a header
// (msg_len) reserves room for a message, payload requests (data_byte) store
// its bytes, and transmit requests hand out the bytes of the full buffer
// being sent. Every request yields exactly one result on the master side;
// loss_count reports the wrapping count of dropped messages. The block works
// on one request at a time. A payload request, an opcode-3 request, a
// transmit request with nothing to send and a header whose write buffer
// is full or sending go straight to their result. Any other header marks
// its write buffer ready and then tries to place the message; a transmit
// request that hands out a byte first does a registered read of the byte
// store. A header that finds the transmitter idle and its write buffer
// open, and the last byte of a buffer, both run the launch sequencer,
// which releases in turn each empty full buffer it meets, at most
// NUM_BUFFERS of them, and starts sending a full buffer that holds bytes
// if it reaches one. The next request can be taken the cycle after the
// result is taken. No clearing pass follows reset: the byte store is only
// read where it was written.
module transmit_buffer_ring_packer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [tbrp_pkg::IN_DATA_W-1:0]  s_tdata,  // msg_len, data_byte
	input  wire logic [1:0]                      s_tuser,  // opcode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [tbrp_pkg::OUT_DATA_W-1:0]      m_tdata,  // accepted, tx_byte, loss_count
	output logic                                 m_tuser,  // tx_valid
	output logic                                 m_tlast   // tx_last
);

	tbrp_pkg::dp_cmd_t    cmd;
	tbrp_pkg::dp_status_t status;

	// sequence each request through the datapath
	tbrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// ring state, byte store and result registers
	tbrp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item_op      (s_tuser),
		.item_data    (s_tdata),
		.res_data     (m_tdata),
		.res_tx_valid (m_tuser),
		.res_tx_last  (m_tlast)
	);

endmodule

`default_nettype wire
